// ----- sv/sha1_pkg.sv -----
`default_nettype none

package sha1_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned ROUND_W = 7;
	localparam int unsigned POS_W   = 4;
	localparam int unsigned COUNT_W = 61;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned NBYTE_W = 3;

	localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
	localparam logic [POS_W-1:0]   POS_LEN_HI = 4'd14;
	localparam logic [POS_W-1:0]   POS_FULL   = 4'd15;
	localparam logic [IDX_W-1:0]   LAST_IDX   = 3'd4;
	localparam logic [NBYTE_W-1:0] FULL_BYTES = 3'd4;
	localparam logic [WORD_W-1:0]  MARK_WORD  = 32'h8000_0000;

	// message word transfer
	typedef struct packed {
		logic [WORD_W-1:0]  data_word;
		logic [NBYTE_W-1:0] valid_bytes;
		logic               last_word;
	} msg_t;

	// digest word transfer
	typedef struct packed {
		logic [WORD_W-1:0] digest_word;
		logic [IDX_W-1:0]  digest_index;
		logic              digest_last;
	} dig_t;

	// working variables of the compression
	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] d;
		logic [WORD_W-1:0] e;
	} work_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_UPDATE,
		ST_PAD,
		ST_OUT
	} state_t;

	// padding progress of the current message
	typedef enum logic [2:0] {
		PH_NONE,
		PH_MARK,
		PH_ZERO,
		PH_LENLO,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		PS_DATA,
		PS_MARK,
		PS_ZERO,
		PS_LENHI,
		PS_LENLO
	} push_sel_t;

	// controls from the sequencer to the datapath
	typedef struct packed {
		logic               push;
		push_sel_t          push_sel;
		logic               expand;
		logic               work_load;
		logic               round_en;
		logic [ROUND_W-1:0] round_idx;
		logic               chain_update;
		logic               restart;
		logic               count_add;
	} ctl_t;

	function automatic logic [WORD_W-1:0] iv_word(input logic [IDX_W-1:0] idx);
		logic [WORD_W-1:0] v;
		unique case (idx)
			3'd0:    v = 32'h6745_2301;
			3'd1:    v = 32'hEFCD_AB89;
			3'd2:    v = 32'h98BA_DCFE;
			3'd3:    v = 32'h1032_5476;
			default: v = 32'hC3D2_E1F0;
		endcase
		return v;
	endfunction

	function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] t);
		logic [WORD_W-1:0] k;
		priority if (t < 7'd20) begin
			k = 32'h5A82_7999;
		end else if (t < 7'd40) begin
			k = 32'h6ED9_EBA1;
		end else if (t < 7'd60) begin
			k = 32'h8F1B_BCDC;
		end else begin
			k = 32'hCA62_C1D6;
		end
		return k;
	endfunction

	function automatic logic [WORD_W-1:0] round_f(
		input logic [ROUND_W-1:0] t,
		input logic [WORD_W-1:0]  b,
		input logic [WORD_W-1:0]  c,
		input logic [WORD_W-1:0]  d
	);
		logic [WORD_W-1:0] f;
		priority if (t < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (t < 7'd40) begin
			f = b ^ c ^ d;
		end else if (t < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

	// short final word: keep the valid bytes and set the marker after them
	function automatic logic [WORD_W-1:0] fmt_last(
		input logic [WORD_W-1:0]  word,
		input logic [NBYTE_W-1:0] nbytes
	);
		logic [WORD_W-1:0] r;
		unique case (nbytes)
			3'd0:    r = 32'h8000_0000;
			3'd1:    r = {word[31:24], 24'h80_0000};
			3'd2:    r = {word[31:16], 16'h8000};
			3'd3:    r = {word[31:8], 8'h80};
			default: r = word;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- sv/sha1_sched.sv -----
`default_nettype none

module sha1_sched (
	input  wire logic        clk,
	input  wire logic        shift,
	input  wire logic        expand,
	input  wire logic [31:0] word_in,
	output logic      [31:0] w_cur
);

	logic [31:0] win_q [16];
	logic [31:0] mix;
	logic [31:0] tail;

	// next schedule word W[t+16] from W[t+13], W[t+8], W[t+2], W[t]
	always_comb begin
		mix  = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
		tail = expand ? {mix[30:0], mix[31]} : word_in;
	end

	// sixteen word window, oldest word at the front
	always_ff @(posedge clk) begin
		if (shift) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= tail;
		end
	end

	assign w_cur = win_q[0];

endmodule

`default_nettype wire

// ----- sv/sha1_round.sv -----
`default_nettype none

module sha1_round (
	input  wire sha1_pkg::work_t             cur,
	input  wire logic [sha1_pkg::ROUND_W-1:0] t,
	input  wire logic [31:0]                 wt,
	output sha1_pkg::work_t                  nxt
);

	logic [31:0] f;
	logic [31:0] tmp;

	// one round of the compression function
	always_comb begin
		f     = sha1_pkg::round_f(t, cur.b, cur.c, cur.d);
		tmp   = {cur.a[26:0], cur.a[31:27]} + cur.e + f + wt + sha1_pkg::round_k(t);
		nxt.a = tmp;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

`default_nettype wire

// ----- sv/sha1_ctrl.sv -----
`default_nettype none

module sha1_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        msg_valid,
	input  wire logic                        msg_last,
	input  wire logic                        msg_full,
	input  wire logic                        dig_ready,
	output logic                             msg_ready,
	output logic                             dig_valid,
	output logic [sha1_pkg::IDX_W-1:0]       dig_idx,
	output sha1_pkg::ctl_t                   ctl
);

	sha1_pkg::state_t state_q, state_d;
	sha1_pkg::phase_t phase_q, phase_d;
	logic [sha1_pkg::POS_W-1:0]   pos_q, pos_d;
	logic [sha1_pkg::ROUND_W-1:0] round_q, round_d;
	logic [sha1_pkg::IDX_W-1:0]   idx_q, idx_d;

	// outputs per state
	always_comb begin
		ctl           = '0;
		ctl.push_sel  = sha1_pkg::PS_DATA;
		ctl.round_idx = round_q;
		msg_ready     = 1'b0;
		dig_valid     = 1'b0;
		unique case (state_q)
			sha1_pkg::ST_IDLE: begin
				msg_ready     = 1'b1;
				ctl.push      = msg_valid;
				ctl.count_add = msg_valid;
			end
			sha1_pkg::ST_ROUND: begin
				ctl.round_en = 1'b1;
				ctl.expand   = 1'b1;
			end
			sha1_pkg::ST_UPDATE: begin
				ctl.chain_update = 1'b1;
			end
			sha1_pkg::ST_PAD: begin
				ctl.push = 1'b1;
				unique case (phase_q)
					sha1_pkg::PH_MARK:  ctl.push_sel = sha1_pkg::PS_MARK;
					sha1_pkg::PH_LENLO: ctl.push_sel = sha1_pkg::PS_LENLO;
					default: begin
						ctl.push_sel = (pos_q == sha1_pkg::POS_LEN_HI) ?
							sha1_pkg::PS_LENHI : sha1_pkg::PS_ZERO;
					end
				endcase
			end
			sha1_pkg::ST_OUT: begin
				dig_valid   = 1'b1;
				ctl.restart = dig_ready && (idx_q == sha1_pkg::LAST_IDX);
			end
			default: begin
			end
		endcase
		ctl.work_load = ctl.push && (pos_q == sha1_pkg::POS_FULL);
	end

	// sequencing
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		pos_d   = ctl.push ? pos_q + 4'd1 : pos_q;
		round_d = round_q;
		idx_d   = idx_q;
		unique case (state_q)
			sha1_pkg::ST_IDLE: begin
				if (msg_valid) begin
					if (msg_last) begin
						phase_d = msg_full ? sha1_pkg::PH_MARK : sha1_pkg::PH_ZERO;
					end else begin
						phase_d = sha1_pkg::PH_NONE;
					end
					if (pos_q == sha1_pkg::POS_FULL) begin
						state_d = sha1_pkg::ST_ROUND;
					end else if (msg_last) begin
						state_d = sha1_pkg::ST_PAD;
					end
				end
			end
			sha1_pkg::ST_ROUND: begin
				if (round_q == sha1_pkg::LAST_ROUND) begin
					round_d = '0;
					state_d = sha1_pkg::ST_UPDATE;
				end else begin
					round_d = round_q + 7'd1;
				end
			end
			sha1_pkg::ST_UPDATE: begin
				unique case (phase_q)
					sha1_pkg::PH_NONE: state_d = sha1_pkg::ST_IDLE;
					sha1_pkg::PH_DONE: state_d = sha1_pkg::ST_OUT;
					default:           state_d = sha1_pkg::ST_PAD;
				endcase
			end
			sha1_pkg::ST_PAD: begin
				unique case (phase_q)
					sha1_pkg::PH_MARK:  phase_d = sha1_pkg::PH_ZERO;
					sha1_pkg::PH_LENLO: phase_d = sha1_pkg::PH_DONE;
					default: begin
						if (pos_q == sha1_pkg::POS_LEN_HI) begin
							phase_d = sha1_pkg::PH_LENLO;
						end
					end
				endcase
				if (pos_q == sha1_pkg::POS_FULL) begin
					state_d = sha1_pkg::ST_ROUND;
				end
			end
			sha1_pkg::ST_OUT: begin
				if (dig_ready) begin
					if (idx_q == sha1_pkg::LAST_IDX) begin
						idx_d   = '0;
						phase_d = sha1_pkg::PH_NONE;
						pos_d   = '0;
						state_d = sha1_pkg::ST_IDLE;
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			end
			default: begin
				state_d = sha1_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha1_pkg::ST_IDLE;
			phase_q <= sha1_pkg::PH_NONE;
			pos_q   <= '0;
			round_q <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			pos_q   <= pos_d;
			round_q <= round_d;
			idx_q   <= idx_d;
		end
	end

	assign dig_idx = idx_q;

	// checks
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg_ready && dig_valid))
		else $error("input and output open at once");

	a_out_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> (pos_q == '0))
		else $error("digest out with partial block");

	a_len_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha1_pkg::ST_PAD && phase_q == sha1_pkg::PH_LENLO)
		|=> (state_q == sha1_pkg::ST_ROUND))
		else $error("length word did not close a block");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		round_q <= sha1_pkg::LAST_ROUND)
		else $error("round counter out of range");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= sha1_pkg::LAST_IDX)
		else $error("digest index out of range");

endmodule

`default_nettype wire

// ----- sv/sha1_hash_engine.sv -----
// a message word is taken while the engine is idle; the 16th word of a block starts
// 80 rounds and then a chain update (one round unit, one round per cycle);
// a final word adds padding words and one or two compressions, then
// five digest transfers; no input while busy
// reset: chaining value to the initial vector, byte count and block position to zero
`default_nettype none

module sha1_hash_engine (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            msg_valid,
	output logic                 msg_ready,
	input  wire sha1_pkg::msg_t  msg,
	output logic                 dig_valid,
	input  wire logic            dig_ready,
	output sha1_pkg::dig_t       dig
);

	sha1_pkg::ctl_t  ctl;
	sha1_pkg::work_t work_q, work_nxt;
	logic [31:0] chain_q [5];
	logic [sha1_pkg::COUNT_W-1:0] count_q;
	logic [sha1_pkg::NBYTE_W-1:0] nbytes;
	logic [sha1_pkg::NBYTE_W-1:0] add_bytes;
	logic        msg_full;
	logic [31:0] push_word;
	logic [31:0] w_cur;
	logic [sha1_pkg::IDX_W-1:0] dig_idx;

	// byte count of the final word, above four taken as four; inner words count as four
	always_comb begin
		msg_full  = (msg.valid_bytes >= sha1_pkg::FULL_BYTES);
		nbytes    = msg_full ? sha1_pkg::FULL_BYTES : msg.valid_bytes;
		add_bytes = msg.last_word ? nbytes : sha1_pkg::FULL_BYTES;
	end

	// word written into the block window
	always_comb begin
		unique case (ctl.push_sel)
			sha1_pkg::PS_DATA: begin
				push_word = msg.last_word ? sha1_pkg::fmt_last(msg.data_word, nbytes)
					: msg.data_word;
			end
			sha1_pkg::PS_MARK:  push_word = sha1_pkg::MARK_WORD;
			sha1_pkg::PS_LENHI: push_word = count_q[60:29];
			sha1_pkg::PS_LENLO: push_word = {count_q[28:0], 3'b000};
			default:            push_word = '0;
		endcase
	end

	sha1_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_last  (msg.last_word),
		.msg_full  (msg_full),
		.dig_ready (dig_ready),
		.msg_ready (msg_ready),
		.dig_valid (dig_valid),
		.dig_idx   (dig_idx),
		.ctl       (ctl)
	);

	sha1_sched u_sched (
		.clk     (clk),
		.shift   (ctl.push | ctl.expand),
		.expand  (ctl.expand),
		.word_in (push_word),
		.w_cur   (w_cur)
	);

	sha1_round u_round (
		.cur (work_q),
		.t   (ctl.round_idx),
		.wt  (w_cur),
		.nxt (work_nxt)
	);

	// working variables
	always_ff @(posedge clk) begin
		if (ctl.work_load) begin
			work_q <= {chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};
		end else if (ctl.round_en) begin
			work_q <= work_nxt;
		end
	end

	// chaining value and message length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) begin
				chain_q[i] <= sha1_pkg::iv_word(3'(i));
			end
			count_q <= '0;
		end else if (ctl.restart) begin
			for (int i = 0; i < 5; i++) begin
				chain_q[i] <= sha1_pkg::iv_word(3'(i));
			end
			count_q <= '0;
		end else begin
			if (ctl.chain_update) begin
				chain_q[0] <= chain_q[0] + work_q.a;
				chain_q[1] <= chain_q[1] + work_q.b;
				chain_q[2] <= chain_q[2] + work_q.c;
				chain_q[3] <= chain_q[3] + work_q.d;
				chain_q[4] <= chain_q[4] + work_q.e;
			end
			if (ctl.count_add) begin
				count_q <= count_q + {{(sha1_pkg::COUNT_W-sha1_pkg::NBYTE_W){1'b0}}, add_bytes};
			end
		end
	end

	// digest transfer
	always_comb begin
		unique case (dig_idx)
			3'd0:    dig.digest_word = chain_q[0];
			3'd1:    dig.digest_word = chain_q[1];
			3'd2:    dig.digest_word = chain_q[2];
			3'd3:    dig.digest_word = chain_q[3];
			default: dig.digest_word = chain_q[4];
		endcase
		dig.digest_index = dig_idx;
		dig.digest_last  = (dig_idx == sha1_pkg::LAST_IDX);
	end

endmodule

`default_nettype wire

// ----- tb/sha1_digest_checker.sv -----
module sha1_digest_checker
	import sha1_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            msg_valid,
	input  wire logic            msg_ready,
	input  wire sha1_pkg::msg_t  msg,
	input  wire logic            dig_valid,
	input  wire logic            dig_ready,
	input  wire sha1_pkg::dig_t  dig,
	output int unsigned          fail_count,
	output int unsigned          digest_pending,
	output int unsigned          digest_matched
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned REPORT_MAX = 10;
	localparam logic [5*WORD_W-1:0] SHA1_IV =
		160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

	// predicted hash state
	logic [WORD_W-1:0]  chain [5];
	logic [WORD_W-1:0]  blk [16];
	logic [POS_W-1:0]   pos;
	logic [COUNT_W-1:0] byte_total;

	// digest words still owed by the block, oldest first
	dig_t digest_q [$];

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [WORD_W-1:0] round_const(input int t);
		if (t < 20) begin
			return 32'h5A82_7999;
		end else if (t < 40) begin
			return 32'h6ED9_EBA1;
		end else if (t < 60) begin
			return 32'h8F1B_BCDC;
		end
		return 32'hCA62_C1D6;
	endfunction

	task automatic restart_hash();
		for (int k = 0; k < 5; k++) begin
			chain[k] = SHA1_IV[5*WORD_W-1-WORD_W*k -: WORD_W];
		end
		pos = '0;
		byte_total = '0;
	endtask

	// 80 rounds over the buffered block, folded into the chaining value
	task automatic compress_block();
		logic [WORD_W-1:0] w [16];
		logic [WORD_W-1:0] a, b, c, d, e, f, wt, tmp;
		for (int i = 0; i < 16; i++) begin
			w[i] = blk[i];
		end
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		e = chain[4];
		for (int t = 0; t < 80; t++) begin
			if (t >= 16) begin
				wt = rotl(w[(t-3) & 15] ^ w[(t-8) & 15] ^ w[(t-14) & 15] ^ w[t & 15], 1);
				w[t & 15] = wt;
			end else begin
				wt = w[t];
			end
			if (t < 20) begin
				f = (b & c) | (~b & d);
			end else if (t < 40) begin
				f = b ^ c ^ d;
			end else if (t < 60) begin
				f = (b & c) | (b & d) | (c & d);
			end else begin
				f = b ^ c ^ d;
			end
			tmp = rotl(a, 5) + e + f + wt + round_const(t);
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = tmp;
		end
		chain[0] = chain[0] + a;
		chain[1] = chain[1] + b;
		chain[2] = chain[2] + c;
		chain[3] = chain[3] + d;
		chain[4] = chain[4] + e;
	endtask

	task automatic push_word(input logic [WORD_W-1:0] word);
		blk[pos] = word;
		pos = pos + 1'b1;
		if (pos == '0) begin
			compress_block();
		end
	endtask

	// absorb one message word; on the final word pad, finish and queue the digest
	task automatic predict_digest(input msg_t m);
		logic [NBYTE_W-1:0] nb;
		logic [WORD_W-1:0]  keep;
		logic [WORD_W-1:0]  mark;
		logic [63:0]        bits;
		dig_t               d;
		if (!m.last_word) begin
			byte_total = byte_total + 61'd4;
			push_word(m.data_word);
		end else begin
			nb = (m.valid_bytes > FULL_BYTES) ? FULL_BYTES : m.valid_bytes;
			byte_total = byte_total + COUNT_W'(nb);
			if (nb == FULL_BYTES) begin
				push_word(m.data_word);
				push_word(MARK_WORD);
			end else begin
				keep = (nb == '0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * nb));
				mark = 32'h80 << (24 - 8 * nb);
				push_word((m.data_word & keep) | mark);
			end
			while (pos != POS_LEN_HI) begin
				push_word('0);
			end
			bits = {byte_total, 3'b000};
			push_word(bits[63:32]);
			push_word(bits[31:0]);
			for (int k = 0; k < 5; k++) begin
				d.digest_word  = chain[k];
				d.digest_index = IDX_W'(k);
				d.digest_last  = (k == 4);
				digest_q.push_back(d);
			end
			restart_hash();
		end
	endtask

	// watch both channels; compare digest transfers before absorbing the message word
	always @(posedge clk or negedge arst_n) begin : watch
		dig_t want;
		if (!arst_n) begin
			restart_hash();
			digest_q.delete();
			fail_count = 0;
			digest_matched = 0;
		end else begin
			if (dig_valid && dig_ready) begin
				if (digest_q.size() == 0) begin
					if (fail_count < REPORT_MAX) begin
						$display("%0t: unexpected digest transfer: word %h index %0d last %b",
							$realtime, dig.digest_word, dig.digest_index, dig.digest_last);
					end
					fail_count++;
				end else begin
					want = digest_q.pop_front();
					if (dig.digest_word !== want.digest_word ||
							dig.digest_index !== want.digest_index ||
							dig.digest_last !== want.digest_last) begin
						if (fail_count < REPORT_MAX) begin
							$display("%0t: digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
								$realtime, want.digest_word, want.digest_index,
								want.digest_last, dig.digest_word, dig.digest_index,
								dig.digest_last);
						end
						fail_count++;
					end else begin
						digest_matched++;
					end
				end
			end
			if (msg_valid && msg_ready) begin
				predict_digest(msg);
			end
		end
		digest_pending = digest_q.size();
	end

endmodule

// ----- tb/sha1_hash_engine_tb.sv -----
module sha1_hash_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sha1_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 11;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 300;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int PHASE_WORDS  = 22;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic msg_valid = 1'b0;
	logic msg_ready;
	msg_t msg = '0;
	logic dig_valid;
	logic dig_ready = 1'b0;
	dig_t dig;

	int unsigned fail_count;
	int unsigned digest_pending;
	int unsigned digest_matched;

	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int cycle_count = 0;
	int words_sent = 0;
	int messages_sent = 0;

	sha1_hash_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.dig       (dig)
	);

	sha1_digest_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg_valid),
		.msg_ready      (msg_ready),
		.msg            (msg),
		.dig_valid      (dig_valid),
		.dig_ready      (dig_ready),
		.dig            (dig),
		.fail_count     (fail_count),
		.digest_pending (digest_pending),
		.digest_matched (digest_matched)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// digest receiver: random stalls, or a long hold-off when asked for
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			dig_ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			dig_ready <= 1'b0;
		end else begin
			dig_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(7))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// final word mostly 1..4 bytes, sometimes zero or above four
	function automatic logic [NBYTE_W-1:0] pick_last_bytes();
		if ($urandom_range(3) == 0) begin
			return NBYTE_W'($urandom_range(7));
		end
		return NBYTE_W'($urandom_range(1, 4));
	endfunction

	// inner words carry a junk byte count now and then
	function automatic logic [NBYTE_W-1:0] pick_inner_bytes();
		if ($urandom_range(4) == 0) begin
			return NBYTE_W'($urandom_range(7));
		end
		return FULL_BYTES;
	endfunction

	// mostly short messages, some near the padding split, a few long
	function automatic int pick_length();
		int r;
		r = $urandom_range(9);
		if (r < 6) begin
			return $urandom_range(1, 8);
		end else if (r < 9) begin
			return $urandom_range(12, 18);
		end
		return $urandom_range(30, 40);
	endfunction

	// one message word transfer, with a random gap in front
	task automatic offer_word(
		input logic [WORD_W-1:0]  data,
		input logic [NBYTE_W-1:0] nbytes,
		input logic               last
	);
		while ($urandom_range(99) < idle_pct) begin
			msg_valid <= 1'b0;
			@(posedge clk);
		end
		msg_valid <= 1'b1;
		msg <= {data, nbytes, last};
		@(negedge clk);
		while (!msg_ready) begin
			@(negedge clk);
		end
		@(posedge clk);
		words_sent++;
		if (last) begin
			messages_sent++;
		end
	endtask

	task automatic send_message(input int nwords);
		for (int i = 0; i < nwords - 1; i++) begin
			offer_word(pick_word(), pick_inner_bytes(), 1'b0);
		end
		offer_word(pick_word(), pick_last_bytes(), 1'b1);
	endtask

	// sender goes quiet until every digest word has come back
	task automatic drain_digests();
		msg_valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (digest_pending != 0);
		@(posedge clk);
	endtask

	initial begin : stimulus
		int phase_start;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// empty message with junk data, then each byte count on a one-word message
		offer_word(32'hDEAD_BEEF, 3'd0, 1'b1);
		offer_word(32'hFFFF_FFFF, 3'd1, 1'b1);
		offer_word(32'hFFFF_FFFF, 3'd2, 1'b1);
		offer_word(32'h6162_6300, 3'd3, 1'b1);
		offer_word(32'hFFFF_FFFF, 3'd3, 1'b1);
		offer_word(32'h0000_0000, 3'd4, 1'b1);
		offer_word(32'h1234_5678, 3'd5, 1'b1);
		offer_word(32'h0000_0000, 3'd6, 1'b1);
		offer_word(32'hFFFF_FFFF, 3'd7, 1'b1);
		// inner word with a short count that must be ignored
		offer_word(32'h1234_5678, 3'd1, 1'b0);
		offer_word(32'hFFFF_FFFF, 3'd3, 1'b1);
		// full last word at slot 13 pushes the length into an extra block
		for (int i = 0; i < 13; i++) begin
			offer_word({4{8'(i + 1)}}, FULL_BYTES, 1'b0);
		end
		offer_word(32'hFFFF_FFFF, FULL_BYTES, 1'b1);
		drain_digests();

		// random messages under four idle/stall mixes
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 60; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 60; end
				default: begin idle_pct = 23; stall_pct = 23; end
			endcase
			if (phase == 0) begin
				hold_req = 1'b1;
			end
			phase_start = words_sent;
			while (words_sent - phase_start < PHASE_WORDS) begin
				send_message(pick_length());
			end
			drain_digests();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d messages in %0d words: empty to 40 words, every byte count,",
			messages_sent, words_sent);
		$display("padding across block ends, a %0d-cycle receiver hold; %0d digest words ok",
			HOLD_CYCLES, digest_matched);
		if (fail_count == 0 && digest_pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
